@@ hdl/flfl_pkg.sv @@
// Shared types and constants for the fixed-length frame link.
`timescale 1ns / 1ps

package flfl_pkg;

	localparam int RX_LEN = 8;
	localparam int TX_LEN = 8;

	localparam int RX_AW  = (RX_LEN > 1) ? $clog2(RX_LEN) : 1;
	localparam int TX_AW  = (TX_LEN > 1) ? $clog2(TX_LEN) : 1;
	localparam int FILL_W = $clog2(RX_LEN + 1);
	localparam int POS_W  = $clog2(TX_LEN + 1);

	localparam logic [15:0] TIMEOUT_RESET = 16'd12500;
	localparam logic [7:0]  BYTE_SPACE    = 8'd32;

	typedef enum logic [2:0] {
		CMD_RX_BYTE = 3'd0,
		CMD_TICK    = 3'd1,
		CMD_GET     = 3'd2,
		CMD_WRITE   = 3'd3,
		CMD_START   = 3'd4,
		CMD_TX_RDY  = 3'd5,
		CMD_ERR_QRY = 3'd6,
		CMD_NOP     = 3'd7
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic exec;
		logic rd_start;
		logic rd_step;
	} ctrl_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;
		logic rx_full;
		logic rd_last;
	} dp_status_t;

endpackage

@@ hdl/flfl_ctrl.sv @@
// Controller state machine: input acceptance and frame readout sequencing.
`timescale 1ns / 1ps

module flfl_ctrl
	import flfl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] cmd,
	input  dp_status_t status,
	output ctrl_cmd_t  ctrl
);

	state_t state_q;
	state_t state_d;
	logic   is_full_get;

	assign is_full_get = (cmd_t'(cmd) == CMD_GET) && status.rx_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && status.out_free && is_full_get) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (status.out_free && status.rd_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		ctrl.exec     = 1'b0;
		ctrl.rd_start = 1'b0;
		ctrl.rd_step  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall      = !status.out_free;
				ctrl.exec     = in_valid && status.out_free && !is_full_get;
				ctrl.rd_start = in_valid && status.out_free && is_full_get;
			end
			ST_READ: begin
				// advance one frame word per free output slot
				ctrl.rd_step = status.out_free;
			end
			default: in_stall = 1'b1;
		endcase
	end

endmodule

@@ hdl/flfl_dp.sv @@
// Datapath: frame buffers, timer, error count, transmit pointer, result register.
`timescale 1ns / 1ps

module flfl_dp
	import flfl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   ctrl,
	output dp_status_t  status,
	input  logic [2:0]  cmd,
	input  logic [7:0]  data_in,
	input  logic [5:0]  tx_index,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [7:0]  data_out,
	output logic        last,
	output logic        tx_valid,
	output logic [7:0]  recent_byte
);

	logic [7:0]        rx_frame_q [RX_LEN];
	logic [7:0]        tx_frame_q [TX_LEN];

	logic [15:0]       timeout_q;
	logic [FILL_W-1:0] rx_fill_q,  rx_fill_d;
	logic [POS_W-1:0]  tx_pos_q,   tx_pos_d;
	logic [15:0]       timer_q,    timer_d;
	logic              running_q,  running_d;
	logic [7:0]        err_q,      err_d;
	logic [7:0]        held_q,     held_d;
	logic [RX_AW-1:0]  rd_idx_q;

	logic              out_valid_q;
	logic              ok_q, last_q, txv_q;
	logic [7:0]        data_q, recent_q;

	logic              res_ok, res_txv;
	logic [7:0]        res_data;
	logic              rx_store, tx_store;
	logic [15:0]       timer_inc;
	logic              rx_full, tx_busy, idx_in_range;

	assign rx_full      = (rx_fill_q == FILL_W'(RX_LEN));
	assign tx_busy      = (tx_pos_q < POS_W'(TX_LEN));
	assign idx_in_range = ({1'b0, tx_index} < 7'(TX_LEN));
	assign timer_inc    = timer_q + 16'd1;

	assign status.rx_full  = rx_full;
	assign status.out_free = !out_valid_q || !out_stall;
	assign status.rd_last  = (rd_idx_q == RX_AW'(RX_LEN - 1));

	always_comb begin
		rx_fill_d = rx_fill_q;
		tx_pos_d  = tx_pos_q;
		timer_d   = timer_q;
		running_d = running_q;
		err_d     = err_q;
		held_d    = held_q;
		res_ok    = 1'b0;
		res_txv   = 1'b0;
		res_data  = 8'd0;
		rx_store  = 1'b0;
		tx_store  = 1'b0;
		unique case (cmd_t'(cmd))
			CMD_RX_BYTE: begin
				held_d = data_in;
				if (!rx_full) begin
					rx_store  = 1'b1;
					rx_fill_d = rx_fill_q + FILL_W'(1);
					timer_d   = 16'd0;
					running_d = 1'b1;
				end
			end
			CMD_TICK: begin
				if (running_q) begin
					timer_d = timer_inc;
					if (timer_inc == timeout_q) begin
						// drop a partial frame on timeout
						if (rx_fill_q != '0 && !rx_full) begin
							rx_fill_d = '0;
							err_d     = err_q + 8'd1;
						end
						running_d = 1'b0;
					end
				end
			end
			CMD_GET: begin
				res_ok = 1'b0;
			end
			CMD_WRITE: begin
				if (!tx_busy && idx_in_range) begin
					tx_store = 1'b1;
					res_ok   = 1'b1;
				end
			end
			CMD_START: begin
				if (!tx_busy) begin
					tx_pos_d = '0;
					res_ok   = 1'b1;
				end
			end
			CMD_TX_RDY: begin
				if (tx_busy) begin
					res_data = tx_frame_q[tx_pos_q[TX_AW-1:0]];
					res_txv  = 1'b1;
					tx_pos_d = tx_pos_q + POS_W'(1);
				end
			end
			CMD_ERR_QRY: begin
				if (err_q != 8'd0) begin
					err_d  = 8'd0;
					res_ok = 1'b1;
				end
			end
			CMD_NOP: begin
				res_ok = 1'b0;
			end
			default: res_ok = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= TIMEOUT_RESET;
			rx_fill_q   <= '0;
			tx_pos_q    <= POS_W'(TX_LEN);
			timer_q     <= 16'd0;
			running_q   <= 1'b0;
			err_q       <= 8'd0;
			held_q      <= BYTE_SPACE;
			rd_idx_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_data;
			end
			if (ctrl.exec) begin
				rx_fill_q   <= rx_fill_d;
				tx_pos_q    <= tx_pos_d;
				timer_q     <= timer_d;
				running_q   <= running_d;
				err_q       <= err_d;
				held_q      <= held_d;
				out_valid_q <= 1'b1;
			end else if (ctrl.rd_step) begin
				out_valid_q <= 1'b1;
				if (status.rd_last) begin
					rd_idx_q  <= '0;
					rx_fill_q <= '0;
				end else begin
					rd_idx_q <= rd_idx_q + RX_AW'(1);
				end
			end else if (ctrl.rd_start) begin
				rd_idx_q <= '0;
				if (!out_stall) begin
					out_valid_q <= 1'b0;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result word and frame stores hold no reset.
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			ok_q     <= res_ok;
			data_q   <= res_data;
			last_q   <= 1'b1;
			txv_q    <= res_txv;
			recent_q <= held_d;
		end else if (ctrl.rd_step) begin
			ok_q     <= 1'b1;
			data_q   <= rx_frame_q[rd_idx_q];
			last_q   <= status.rd_last;
			txv_q    <= 1'b0;
			recent_q <= held_q;
		end
		if (ctrl.exec && rx_store) begin
			rx_frame_q[rx_fill_q[RX_AW-1:0]] <= data_in;
		end
		if (ctrl.exec && tx_store) begin
			tx_frame_q[tx_index[TX_AW-1:0]] <= data_in;
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign data_out    = data_q;
	assign last        = last_q;
	assign tx_valid    = txv_q;
	assign recent_byte = recent_q;

endmodule

@@ hdl/fixed_length_frame_link_with_timeout_unit.sv @@
// Fixed-length frame link with receive timeout: accepts one command word per cycle
// while in_stall is low and presents its result word in the cycle after acceptance.
// A get of a full frame stalls the input while ST_READ reads the frame out: the
// frame words are registered one per cycle while out_stall does not hold them.
// A result word held by out_stall stalls the input until it is taken.
// arst_n clears all control state at once; frame buffers stay undefined until written.
`timescale 1ns / 1ps

module fixed_length_frame_link_with_timeout_unit
	import flfl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  cmd,
	input  logic [7:0]  data_in,
	input  logic [5:0]  tx_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [7:0]  data_out,
	output logic        last,
	output logic        tx_valid,
	output logic [7:0]  recent_byte
);

	ctrl_cmd_t  ctrl;
	dp_status_t status;

	flfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.status   (status),
		.ctrl     (ctrl)
	);

	flfl_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.status      (status),
		.cmd         (cmd),
		.data_in     (data_in),
		.tx_index    (tx_index),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.data_out    (data_out),
		.last        (last),
		.tx_valid    (tx_valid),
		.recent_byte (recent_byte)
	);

endmodule

@@ dv/fixed_length_frame_link_with_timeout_unit_tb.sv @@
// Self-checking testbench for the fixed-length frame link with receive timeout.
`timescale 1ns / 1ps

module fixed_length_frame_link_with_timeout_unit_tb;
	import flfl_pkg::*;

	localparam int SETTLE_CYCLES = RX_LEN + 4;
	localparam int STALL_LIMIT   = 5000;
	localparam int RANDOM_WORDS  = 10;

	typedef struct {
		logic       ok;
		logic [7:0] data;
		logic       last;
		logic       txv;
		logic [7:0] recent;
	} reply_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        cfg_we   = 1'b0;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	cmd_t        cmd      = CMD_NOP;
	logic [7:0]  data_in  = '0;
	logic [5:0]  tx_index = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ok;
	logic [7:0]  data_out;
	logic        last;
	logic        tx_valid;
	logic [7:0]  recent_byte;

	// Predicted link state
	logic [7:0]  rx_buf [RX_LEN];
	int          rx_cnt      = 0;
	logic [7:0]  tx_buf [TX_LEN];
	int          tx_pos      = TX_LEN;
	logic [15:0] tmr         = '0;
	logic        tmr_on      = 1'b0;
	logic [7:0]  err_cnt     = '0;
	logic [7:0]  held        = BYTE_SPACE;
	logic [15:0] timeout_lim = TIMEOUT_RESET;

	reply_t      replies_due [$];
	int          errors       = 0;
	int          quiet_cycles = 0;
	int          words_sent   = 0;
	bit          idle_on      = 1'b1;
	bit          stall_on     = 1'b1;

	fixed_length_frame_link_with_timeout_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.data_in     (data_in),
		.tx_index    (tx_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.data_out    (data_out),
		.last        (last),
		.tx_valid    (tx_valid),
		.recent_byte (recent_byte)
	);

	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= stall_on && ($urandom_range(99) < 15);
	end

	function automatic void push_reply(logic ok_v, logic [7:0] d, logic fin, logic txv);
		reply_t r;
		r.ok     = ok_v;
		r.data   = d;
		r.last   = fin;
		r.txv    = txv;
		r.recent = held;
		replies_due.push_back(r);
	endfunction

	function automatic void update_link_state(cmd_t c, logic [7:0] d, logic [5:0] idx);
		logic ok_v;
		ok_v = 1'b0;
		unique case (c)
			CMD_RX_BYTE: begin
				held = d;
				if (rx_cnt < RX_LEN) begin
					rx_buf[rx_cnt] = d;
					rx_cnt++;
					tmr    = '0;
					tmr_on = 1'b1;
				end
			end
			CMD_TICK: begin
				if (tmr_on) begin
					tmr = tmr + 16'd1;
					if (tmr == timeout_lim) begin
						// drop a partial frame only
						if (rx_cnt > 0 && rx_cnt < RX_LEN) begin
							rx_cnt  = 0;
							err_cnt = err_cnt + 8'd1;
						end
						tmr_on = 1'b0;
					end
				end
			end
			CMD_GET: begin
				if (rx_cnt >= RX_LEN) begin
					for (int k = 0; k < RX_LEN; k++)
						push_reply(1'b1, rx_buf[k], k == RX_LEN - 1, 1'b0);
					rx_cnt = 0;
					return;
				end
			end
			CMD_WRITE: begin
				if (tx_pos >= TX_LEN && idx < TX_LEN) begin
					tx_buf[idx] = d;
					ok_v        = 1'b1;
				end
			end
			CMD_START: begin
				if (tx_pos >= TX_LEN) begin
					tx_pos = 0;
					ok_v   = 1'b1;
				end
			end
			CMD_TX_RDY: begin
				if (tx_pos < TX_LEN) begin
					push_reply(1'b0, tx_buf[tx_pos], 1'b1, 1'b1);
					tx_pos++;
					return;
				end
			end
			CMD_ERR_QRY: begin
				if (err_cnt != 0) begin
					err_cnt = '0;
					ok_v    = 1'b1;
				end
			end
			default: ;
		endcase
		push_reply(ok_v, 8'h00, 1'b1, 1'b0);
	endfunction

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_replies
		reply_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (replies_due.size() == 0) begin
				errors++;
				$display("%0t ns: result word expected none, got data_out %0h",
					$time, data_out);
			end else begin
				r = replies_due.pop_front();
				check_field("ok", r.ok, ok);
				check_field("data_out", r.data, data_out);
				check_field("last", r.last, last);
				check_field("tx_valid", r.txv, tx_valid);
				check_field("recent_byte", r.recent, recent_byte);
			end
		end
	end

	// End the run once no word has moved on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("** fixed_length_frame_link_with_timeout_unit: FAILED **");
				$finish;
			end
		end
	end

	task automatic send_word(cmd_t c, logic [7:0] d = 8'h00, logic [5:0] idx = 6'd0);
		@(negedge clk);
		if (idle_on && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= c;
		data_in  <= d;
		tx_index <= idx;
		do @(posedge clk); while (in_stall);
		update_link_state(c, d, idx);
		words_sent++;
	endtask

	// Hold the sender until every pending result is back and the block settles.
	task automatic drain_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_timeout(logic [15:0] v);
		@(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_we   <= 1'b0;
		timeout_lim = v;
	endtask

	task automatic fill_rx(int n);
		repeat (n) send_word(CMD_RX_BYTE, 8'($urandom));
	endtask

	task automatic test_tx_load();
		for (int i = 0; i < TX_LEN; i++)
			send_word(CMD_WRITE, 8'(i * 37), 6'(i));
		send_word(CMD_WRITE, 8'hFF, 6'(TX_LEN - 1));
		// out-of-range positions are refused
		send_word(CMD_WRITE, 8'h12, 6'(TX_LEN));
		send_word(CMD_WRITE, 8'h34, 6'h3F);
	endtask

	task automatic test_send_path();
		send_word(CMD_TX_RDY);
		send_word(CMD_START);
		send_word(CMD_WRITE, 8'h5A, 6'd2);
		send_word(CMD_START);
		repeat (TX_LEN) send_word(CMD_TX_RDY);
		send_word(CMD_TX_RDY);
		send_word(CMD_NOP, 8'hFF, 6'h3F);
	endtask

	task automatic test_rx_frame();
		send_word(CMD_GET);
		send_word(CMD_RX_BYTE, 8'h00);
		fill_rx(RX_LEN - 2);
		send_word(CMD_RX_BYTE, 8'hFF);
		// frame is full: byte only updates the recent byte
		send_word(CMD_RX_BYTE, 8'h7E);
		send_word(CMD_GET);
		send_word(CMD_GET);
		send_word(CMD_ERR_QRY);
	endtask

	task automatic test_timeout();
		drain_replies();
		set_timeout(16'd1);
		send_word(CMD_RX_BYTE, 8'h11);
		send_word(CMD_TICK);
		send_word(CMD_ERR_QRY);
		send_word(CMD_ERR_QRY);
		send_word(CMD_TICK);
		drain_replies();
		set_timeout(16'd2);
		// a full frame survives the timeout
		fill_rx(RX_LEN);
		repeat (2) send_word(CMD_TICK);
		send_word(CMD_GET);
		// timer keeps running after a get empties the frame
		fill_rx(RX_LEN);
		send_word(CMD_GET);
		repeat (2) send_word(CMD_TICK);
		send_word(CMD_ERR_QRY);
	endtask

	task automatic test_error_count();
		drain_replies();
		set_timeout(16'd1);
		repeat (3) begin
			send_word(CMD_RX_BYTE, 8'($urandom));
			send_word(CMD_TICK);
		end
		send_word(CMD_ERR_QRY);
		send_word(CMD_ERR_QRY);
	endtask

	task automatic test_timeout_below_count();
		drain_replies();
		set_timeout(16'd20);
		send_word(CMD_RX_BYTE, 8'hC3);
		repeat (10) send_word(CMD_TICK);
		drain_replies();
		// limit now below the count: reached only after the counter wraps
		set_timeout(16'd5);
		idle_on  = 1'b0;
		stall_on = 1'b0;
		repeat (6) send_word(CMD_TICK);
		send_word(CMD_GET);
		send_word(CMD_ERR_QRY);
		idle_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	task automatic run_scenario();
		int pick;
		pick = $urandom_range(99);
		if (pick < 40) begin
			fill_rx($urandom_range(1, RX_LEN + 2));
			repeat ($urandom_range(0, 3)) send_word(CMD_TICK);
			send_word(CMD_GET);
		end else if (pick < 65) begin
			repeat ($urandom_range(1, TX_LEN))
				send_word(CMD_WRITE, 8'($urandom), ($urandom_range(9) == 0) ?
					6'($urandom_range(TX_LEN, 63)) : 6'($urandom_range(0, TX_LEN - 1)));
			send_word(CMD_START);
			repeat ($urandom_range(0, TX_LEN + 2)) send_word(CMD_TX_RDY);
		end else if (pick < 80) begin
			repeat ($urandom_range(1, 6)) send_word(CMD_TICK);
		end else begin
			send_word(cmd_t'($urandom_range(0, 7)), 8'($urandom), 6'($urandom));
		end
	endtask

	task automatic test_random();
		logic [15:0] limits [3];
		int          stop_at;
		limits = '{16'd2, 16'hFFFF, 16'd0};
		limits[2] = 16'($urandom_range(3, 9));
		foreach (limits[s]) begin
			drain_replies();
			set_timeout(limits[s]);
			// middle round runs with no idling on either side
			idle_on  = (s != 1);
			stall_on = (s != 1);
			stop_at = words_sent + RANDOM_WORDS;
			while (words_sent < stop_at) run_scenario();
		end
		idle_on  = 1'b1;
		stall_on = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_tx_load();
		test_send_path();
		test_rx_frame();
		test_timeout();
		test_error_count();
		test_timeout_below_count();
		test_random();
		drain_replies();
		if (errors == 0 && replies_due.size() == 0)
			$display("** fixed_length_frame_link_with_timeout_unit: PASSED **");
		else
			$display("** fixed_length_frame_link_with_timeout_unit: FAILED **");
		$finish;
	end

endmodule
